// File: hdl/fte_pkg.sv
`default_nettype none

package fte_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 4096;

    localparam int unsigned KIND_W      = 3;
    localparam int unsigned BYTE_ADDR_W = 13;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CLUSTER_W   = 12;
    localparam int unsigned START_W     = 32;
    localparam int unsigned SPC_W       = 8;
    localparam int unsigned BPS_W       = 13;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned S_TDATA_W   = 48;
    localparam int unsigned M_TDATA_W   = 72;
    localparam int unsigned RESULT_W    = 65;

    localparam int unsigned SCAN_END_MAX = 4088;

    localparam logic [CLUSTER_W-1:0] CLUSTER_LAST       = 12'hFF8;
    localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 12'd2;
    localparam logic [CLUSTER_W-1:0] RESERVED_NEXT      = 12'd1;

    localparam logic [START_W-1:0] START_RESET = 32'd0;
    localparam logic [SPC_W-1:0]   SPC_RESET   = 8'd1;
    localparam logic [BPS_W-1:0]   BPS_RESET   = 13'd512;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_BYTE   = 3'd0,
        KIND_READ_BYTE   = 3'd1,
        KIND_READ_ENTRY  = 3'd2,
        KIND_WRITE_ENTRY = 3'd3,
        KIND_FIND_FREE   = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DATA_START   = 2'd0,
        REG_SECTORS      = 2'd1,
        REG_BYTES_SECTOR = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_SCAN,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic                 status;
        logic [START_W-1:0]   cluster_offset;
        logic [CLUSTER_W-1:0] free_cluster;
        logic [CLUSTER_W-1:0] entry_value;
        logic [BYTE_W-1:0]    read_byte;
    } t_result;

    // odd entries sit in the upper 12 bits of the word
    function automatic logic [CLUSTER_W-1:0] entry_field(input logic [15:0] w,
                                                         input logic odd);
        return odd ? w[15:4] : w[11:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/fat12_table_engine_core.sv
`default_nettype none

// FAT12 allocation table engine. The table is kept as packed bytes in two
// synchronous byte banks (even and odd addresses), so the 16-bit word behind
// any entry is fetched in a single read. Byte loads, byte reads, entry reads
// and entry writes each issue the bank read, then merge, write back and
// register the result; a byte load writes its byte as the read is issued.
// Find-free inspects up to 4086 entries, one entry per cycle through the bank
// read ports. One transfer is in flight at a time; a finished result waits in
// the output register while the next transfer is taken, or in a hold register,
// with no transfer taken, while the output register is full. The table has no
// reset: every byte must be loaded before it is read.
module fat12_table_engine_core #(
    parameter int unsigned TABLE_ENTRIES = fte_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // byte_address[12:0], byte_value[20:13], cluster[32:21], next_cluster[44:33]
    input  wire  [fte_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // kind[2:0]
    input  wire  [fte_pkg::KIND_W-1:0]       i_s_tuser,
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // read_byte[7:0], entry_value[19:8], free_cluster[31:20],
    // cluster_offset[63:32], status[64]
    output logic [fte_pkg::M_TDATA_W-1:0]    o_m_tdata,
    input  wire                              i_cfg_we,
    input  wire  [fte_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [fte_pkg::START_W-1:0]      i_cfg_data
);

    localparam int unsigned TABLE_BYTES = TABLE_ENTRIES * 3 / 2 + 1;
    localparam int unsigned DEPTH_E     = (TABLE_BYTES + 1) / 2;
    localparam int unsigned DEPTH_O     = TABLE_BYTES / 2;
    localparam int unsigned ROW_E_W     = $clog2(DEPTH_E);
    localparam int unsigned ROW_O_W     = $clog2(DEPTH_O);
    localparam int unsigned SCAN_END    = (TABLE_ENTRIES < fte_pkg::SCAN_END_MAX) ?
                                          TABLE_ENTRIES : fte_pkg::SCAN_END_MAX;
    localparam logic [fte_pkg::CLUSTER_W-1:0] SCAN_LAST = fte_pkg::CLUSTER_W'(SCAN_END - 1);

    localparam int unsigned AW = fte_pkg::BYTE_ADDR_W;
    localparam int unsigned CW = fte_pkg::CLUSTER_W;
    localparam int unsigned BW = fte_pkg::BYTE_W;

    // configuration
    logic [fte_pkg::START_W-1:0] r_start;
    logic [fte_pkg::SPC_W-1:0]   r_spc;
    logic [fte_pkg::BPS_W-1:0]   r_bps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= fte_pkg::START_RESET;
            r_spc   <= fte_pkg::SPC_RESET;
            r_bps   <= fte_pkg::BPS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fte_pkg::REG_DATA_START:   r_start <= i_cfg_data;
                fte_pkg::REG_SECTORS:      r_spc   <= i_cfg_data[fte_pkg::SPC_W-1:0];
                fte_pkg::REG_BYTES_SECTOR: r_bps   <= i_cfg_data[fte_pkg::BPS_W-1:0];
                default: ;
            endcase
        end
    end

    // input fields
    logic [AW-1:0] s_addr;
    logic [BW-1:0] s_bval;
    logic [CW-1:0] s_clus;
    logic [CW-1:0] s_next;
    logic          s_fire;

    assign s_addr = i_s_tdata[12:0];
    assign s_bval = i_s_tdata[20:13];
    assign s_clus = i_s_tdata[32:21];
    assign s_next = i_s_tdata[44:33];

    fte_pkg::t_state r_state, n_state;

    assign o_s_tready = (r_state == fte_pkg::ST_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;

    logic [CW-1:0] r_chk, n_chk;

    // read address: byte address, or the byte position of an entry word
    logic [AW-1:0]      rd_a;
    logic [AW:0]        rd_a_inc;
    logic [AW-1:0]      row_e;
    logic [AW-2:0]      row_o;
    logic               ok_e;
    logic               ok_o;
    logic [ROW_E_W-1:0] idx_e;
    logic [ROW_O_W-1:0] idx_o;

    always_comb begin
        logic [CW-1:0] n;
        n = s_clus;
        if (r_state == fte_pkg::ST_SCAN) begin
            n = r_chk + 1'b1;
        end else if (i_s_tuser == fte_pkg::KIND_FIND_FREE) begin
            n = fte_pkg::FIRST_DATA_CLUSTER;
        end
        rd_a = {1'b0, n} + {2'b00, n[CW-1:1]};
        if (r_state != fte_pkg::ST_SCAN &&
            (i_s_tuser == fte_pkg::KIND_LOAD_BYTE || i_s_tuser == fte_pkg::KIND_READ_BYTE)) begin
            rd_a = s_addr;
        end
    end

    assign rd_a_inc = {1'b0, rd_a} + 1'b1;
    assign row_e    = rd_a_inc[AW:1];
    assign row_o    = rd_a[AW-1:1];
    assign ok_e     = row_e < AW'(DEPTH_E);
    assign ok_o     = {1'b0, row_o} < AW'(DEPTH_O);
    assign idx_e    = row_e[ROW_E_W-1:0];
    assign idx_o    = row_o[ROW_O_W-1:0];

    // captured with each issued read
    logic               r_swap;
    logic               r_ok_e;
    logic               r_ok_o;
    logic [ROW_E_W-1:0] r_idx_e;
    logic [ROW_O_W-1:0] r_idx_o;

    always_ff @(posedge i_clk) begin
        r_swap  <= rd_a[0];
        r_ok_e  <= ok_e;
        r_ok_o  <= ok_o;
        r_idx_e <= idx_e;
        r_idx_o <= idx_o;
    end

    // transfer payload
    logic [fte_pkg::KIND_W-1:0]  r_kind;
    logic [CW-1:0]               r_clus;
    logic [CW-1:0]               r_next;
    logic [fte_pkg::START_W-1:0] r_prod1;
    logic [AW-1:0]               clus_m2;
    logic signed [21:0]          prod1;

    assign clus_m2 = {1'b0, s_clus} - AW'(fte_pkg::FIRST_DATA_CLUSTER);
    assign prod1   = $signed(clus_m2) * $signed({1'b0, r_spc});

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_kind  <= i_s_tuser;
            r_clus  <= s_clus;
            r_next  <= s_next;
            r_prod1 <= {{(fte_pkg::START_W - 22){prod1[21]}}, prod1};
        end
    end

    // byte banks
    logic [BW-1:0]      mem_e [DEPTH_E];
    logic [BW-1:0]      mem_o [DEPTH_O];
    logic [BW-1:0]      r_rd_e;
    logic [BW-1:0]      r_rd_o;
    logic               we_e;
    logic               we_o;
    logic [ROW_E_W-1:0] wa_e;
    logic [ROW_O_W-1:0] wa_o;
    logic [BW-1:0]      wd_e;
    logic [BW-1:0]      wd_o;

    always_ff @(posedge i_clk) begin
        if (we_e) begin
            mem_e[wa_e] <= wd_e;
        end
        r_rd_e <= mem_e[idx_e];
    end

    always_ff @(posedge i_clk) begin
        if (we_o) begin
            mem_o[wa_o] <= wd_o;
        end
        r_rd_o <= mem_o[idx_o];
    end

    // word assembly and merge
    logic [BW-1:0] rde;
    logic [BW-1:0] rdo;
    logic [BW-1:0] lo_byte;
    logic [BW-1:0] hi_byte;
    logic [15:0]   word;
    logic [15:0]   merged;
    logic [CW-1:0] entry;
    logic          entry_odd;
    logic          reject;
    logic          do_write;
    logic          do_load;
    logic [44:0]   prod2;
    logic [fte_pkg::START_W-1:0] offset;

    assign rde       = r_ok_e ? r_rd_e : '0;
    assign rdo       = r_ok_o ? r_rd_o : '0;
    assign lo_byte   = r_swap ? rdo : rde;
    assign hi_byte   = r_swap ? rde : rdo;
    assign word      = {hi_byte, lo_byte};
    assign entry_odd = (r_state == fte_pkg::ST_SCAN) ? r_chk[0] : r_clus[0];
    assign entry     = fte_pkg::entry_field(word, entry_odd);
    assign merged    = r_clus[0] ? {r_next, word[3:0]} : {word[15:12], r_next};
    assign reject    = (r_clus > fte_pkg::CLUSTER_LAST) ||
                       (r_clus < fte_pkg::FIRST_DATA_CLUSTER) ||
                       (r_next == fte_pkg::RESERVED_NEXT);
    assign prod2     = r_prod1 * r_bps;
    assign offset    = r_start + prod2[fte_pkg::START_W-1:0];

    assign do_write = (r_state == fte_pkg::ST_ACCESS) &&
                      (r_kind == fte_pkg::KIND_WRITE_ENTRY) && !reject;
    assign do_load  = s_fire && (i_s_tuser == fte_pkg::KIND_LOAD_BYTE);

    always_comb begin
        we_e = 1'b0;
        we_o = 1'b0;
        wa_e = idx_e;
        wa_o = idx_o;
        wd_e = s_bval;
        wd_o = s_bval;
        if (do_write) begin
            we_e = r_ok_e;
            we_o = r_ok_o;
            wa_e = r_idx_e;
            wa_o = r_idx_o;
            wd_e = r_swap ? merged[15:8] : merged[7:0];
            wd_o = r_swap ? merged[7:0] : merged[15:8];
        end else if (do_load) begin
            we_e = !rd_a[0] && ok_e;
            we_o = rd_a[0] && ok_o;
        end
    end

    // control
    fte_pkg::t_result res;
    fte_pkg::t_result r_out;
    fte_pkg::t_result r_hold;
    logic             r_out_valid;
    logic             res_done;
    logic             slot_free;

    assign slot_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fte_pkg::ST_IDLE;
            r_chk   <= fte_pkg::FIRST_DATA_CLUSTER;
        end else begin
            r_state <= n_state;
            r_chk   <= n_chk;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_chk    = r_chk;
        res      = '0;
        res_done = 1'b0;
        case (r_state)
            fte_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (i_s_tuser == fte_pkg::KIND_FIND_FREE) begin
                        n_state = fte_pkg::ST_SCAN;
                        n_chk   = fte_pkg::FIRST_DATA_CLUSTER;
                    end else begin
                        n_state = fte_pkg::ST_ACCESS;
                    end
                end
            end
            fte_pkg::ST_ACCESS: begin
                res_done = 1'b1;
                case (r_kind)
                    fte_pkg::KIND_READ_BYTE: begin
                        res.read_byte = lo_byte;
                    end
                    fte_pkg::KIND_READ_ENTRY: begin
                        res.entry_value    = entry;
                        res.cluster_offset = offset;
                    end
                    fte_pkg::KIND_WRITE_ENTRY: begin
                        res.cluster_offset = offset;
                        res.status         = reject;
                    end
                    default: ;
                endcase
            end
            fte_pkg::ST_SCAN: begin
                if (entry == '0) begin
                    res_done         = 1'b1;
                    res.free_cluster = r_chk;
                end else if (r_chk == SCAN_LAST) begin
                    res_done = 1'b1;
                end else begin
                    n_chk = r_chk + 1'b1;
                end
            end
            fte_pkg::ST_HOLD: begin
                if (slot_free) begin
                    n_state = fte_pkg::ST_IDLE;
                end
            end
            default: n_state = fte_pkg::ST_IDLE;
        endcase
        if (res_done) begin
            n_state = slot_free ? fte_pkg::ST_IDLE : fte_pkg::ST_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((res_done || r_state == fte_pkg::ST_HOLD) && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_done && slot_free) begin
            r_out <= res;
        end else if (r_state == fte_pkg::ST_HOLD && slot_free) begin
            r_out <= r_hold;
        end
        if (res_done && !slot_free) begin
            r_hold <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(fte_pkg::M_TDATA_W - fte_pkg::RESULT_W)'(0), r_out};

    // checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> !o_s_tready)
        else $error("input taken while a transfer is in progress");

    a_write_only_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fte_pkg::ST_ACCESS && (we_e || we_o)) |->
            (r_kind == fte_pkg::KIND_WRITE_ENTRY && !reject))
        else $error("table written by a transfer that must not write");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fte_pkg::ST_SCAN) |->
            (r_chk >= fte_pkg::FIRST_DATA_CLUSTER && r_chk <= SCAN_LAST))
        else $error("free scan outside entry range");

    a_hold_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fte_pkg::ST_HOLD) |-> r_out_valid)
        else $error("result held while output register empty");

endmodule

`default_nettype wire
